// ----- src/pzb_pkg.sv -----
// pzb_pkg: shared types and constants for the pole-zero biquad filter
// no dependencies; imported by pzb_cfg_if, pzb_round_sat, pzb_datapath and the top level
`timescale 1ns / 1ps
`default_nettype none

package pzb_pkg;

  // coefficient format, Q2.14
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 14;

  // extra integer bits of the form II intermediate value over the sample
  localparam int W_GUARD = 8;

  // configuration register file
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_FORM   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_COEF_TWO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_ONE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POLE_COEF_TWO = 3'd4;

  // filter structure select
  localparam logic FORM_DF1 = 1'b0;
  localparam logic FORM_DF2 = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;

  // coefficient set handed to the datapath
  typedef struct packed {
    coef_t b1;
    coef_t b2;
    coef_t a1;
    coef_t a2;
  } pzb_coef_t;

  // clip status from the three rounding stages
  typedef struct packed {
    logic clip_df1;
    logic clip_w;
    logic clip_df2;
  } pzb_clip_t;

endpackage : pzb_pkg

`default_nettype wire

// ----- src/pzb_in_if.sv -----
// pzb_in_if: valid/ready channel carrying one input sample
// depends on nothing; width set by the instantiating level
`timescale 1ns / 1ps
`default_nettype none

interface pzb_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface : pzb_in_if

`default_nettype wire

// ----- src/pzb_out_if.sv -----
// pzb_out_if: valid/ready channel carrying one filtered sample and its flags
// depends on nothing; width set by the instantiating level
`timescale 1ns / 1ps
`default_nettype none

interface pzb_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;
  logic                           saturated;
  logic                           block_first;

  modport source (output valid, output out_sample, output saturated,
                  output block_first, input ready);
  modport sink   (input valid, input out_sample, input saturated,
                  input block_first, output ready);
endinterface : pzb_out_if

`default_nettype wire

// ----- src/pzb_cfg_if.sv -----
// pzb_cfg_if: register write channel, index plus write data
// depends on pzb_pkg for the index and data widths
`timescale 1ns / 1ps
`default_nettype none

interface pzb_cfg_if
  import pzb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : pzb_cfg_if

`default_nettype wire

// ----- src/pzb_round_sat.sv -----
// pzb_round_sat: round a Q.14-scaled sum half up to sample scale, then clip
// depends on pzb_pkg for the fraction width
`timescale 1ns / 1ps
`default_nettype none

module pzb_round_sat
  import pzb_pkg::*;
#(
  parameter int IN_W  = 43,
  parameter int OUT_W = 16
) (
  input  wire logic signed [IN_W-1:0]  acc,
  output      logic signed [OUT_W-1:0] res,
  output      logic                    clip
);

  localparam logic signed [IN_W-1:0] HALF = IN_W'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [IN_W-1:0] HI   =
    {{(IN_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] LO   = ~HI;

  logic signed [IN_W-1:0] rnd;

  // round half up with floor shift
  assign rnd = (acc + HALF) >>> COEF_FRAC;

  // clip to the output range
  always_comb begin
    clip = 1'b0;
    res  = OUT_W'(rnd);
    if (rnd > HI) begin
      clip = 1'b1;
      res  = OUT_W'(HI);
    end else if (rnd < LO) begin
      clip = 1'b1;
      res  = OUT_W'(LO);
    end
  end

endmodule : pzb_round_sat

`default_nettype wire

// ----- src/pzb_datapath.sv -----
// pzb_datapath: one-pass arithmetic for both filter forms from current history
// depends on pzb_pkg and pzb_round_sat
`timescale 1ns / 1ps
`default_nettype none

module pzb_datapath
  import pzb_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic signed [SAMPLE_WIDTH-1:0]         x,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         x1,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         x2,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         y1,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         y2,
  input  wire logic signed [SAMPLE_WIDTH+W_GUARD-1:0] w1,
  input  wire logic signed [SAMPLE_WIDTH+W_GUARD-1:0] w2,
  input  wire pzb_coef_t                              coef,
  output      logic signed [SAMPLE_WIDTH-1:0]         y_df1,
  output      logic signed [SAMPLE_WIDTH-1:0]         y_df2,
  output      logic signed [SAMPLE_WIDTH+W_GUARD-1:0] w,
  output      pzb_clip_t                              clip
);

  localparam int WW  = SAMPLE_WIDTH + W_GUARD;
  localparam int PXW = SAMPLE_WIDTH + COEF_W;   // sample by coefficient
  localparam int PWW = WW + COEF_W;             // w by coefficient
  localparam int AW  = WW + COEF_W + 3;         // accumulator, all sums

  logic signed [PXW-1:0] p_b1x1, p_b2x2, p_a1y1, p_a2y2;
  logic signed [PWW-1:0] p_a1w1, p_a2w2, p_b1w1, p_b2w2;
  logic signed [AW-1:0]  acc_df1, acc_w, acc_df2;

  // form I products on sample and output history
  assign p_b1x1 = PXW'(coef.b1) * PXW'(x1);
  assign p_b2x2 = PXW'(coef.b2) * PXW'(x2);
  assign p_a1y1 = PXW'(coef.a1) * PXW'(y1);
  assign p_a2y2 = PXW'(coef.a2) * PXW'(y2);

  // form II products on intermediate history
  assign p_a1w1 = PWW'(coef.a1) * PWW'(w1);
  assign p_a2w2 = PWW'(coef.a2) * PWW'(w2);
  assign p_b1w1 = PWW'(coef.b1) * PWW'(w1);
  assign p_b2w2 = PWW'(coef.b2) * PWW'(w2);

  // form I sum
  assign acc_df1 = (AW'(x) <<< COEF_FRAC) + AW'(p_b1x1) + AW'(p_b2x2)
                 - AW'(p_a1y1) - AW'(p_a2y2);

  // form II recursive part
  assign acc_w = (AW'(x) <<< COEF_FRAC) - AW'(p_a1w1) - AW'(p_a2w2);

  // form II feed-forward part, on the clipped new w
  assign acc_df2 = (AW'(w) <<< COEF_FRAC) + AW'(p_b1w1) + AW'(p_b2w2);

  pzb_round_sat #(.IN_W(AW), .OUT_W(SAMPLE_WIDTH)) u_rs_df1 (
    .acc  (acc_df1),
    .res  (y_df1),
    .clip (clip.clip_df1)
  );

  pzb_round_sat #(.IN_W(AW), .OUT_W(WW)) u_rs_w (
    .acc  (acc_w),
    .res  (w),
    .clip (clip.clip_w)
  );

  pzb_round_sat #(.IN_W(AW), .OUT_W(SAMPLE_WIDTH)) u_rs_df2 (
    .acc  (acc_df2),
    .res  (y_df2),
    .clip (clip.clip_df2)
  );

endmodule : pzb_datapath

`default_nettype wire

// ----- src/pole_zero_biquad_filter.sv -----
// pole_zero_biquad_filter: top level, handshakes, registers, history and block count
// depends on pzb_pkg, the pzb_*_if interfaces and pzb_datapath
`timescale 1ns / 1ps
`default_nettype none

// Second-order pole-zero filter (b0 = a0 = 1) on a stream of signed samples.
// Throughput is one sample per clock when out_if.ready does not stall the
// result: a sample is captured in an input register, filtered in one
// combinational pass (eight coefficient multiplies, three round-and-clip
// stages) and lands in the result register. That rate is set by the history
// feedback loop, which closes through that pass at every result.
// filter_form picks direct form I or II; both are computed and all
// histories advance on every sample, so a form change takes effect at once.
// History is treated as zero on the first sample of every BLOCK_LEN block,
// and block_first marks that sample. saturated flags a clipped result (in
// form II also a clipped intermediate). Write coefficients (Q2.14) only while
// the filter is idle; the configuration port is always ready. No clearing
// pass is needed after reset.
module pole_zero_biquad_filter
  import pzb_pkg::*;
#(
  parameter int BLOCK_LEN    = 512,
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pzb_in_if.sink    in_if,
  pzb_out_if.source out_if,
  pzb_cfg_if.sink   cfg_if
);

  localparam int WW   = SAMPLE_WIDTH + W_GUARD;
  localparam int BP_W = (BLOCK_LEN > 2) ? $clog2(BLOCK_LEN) : 1;
  localparam logic [BP_W-1:0] BP_LAST = BP_W'(BLOCK_LEN - 1);

  // configuration registers
  logic      form_r;
  pzb_coef_t coef_r;

  // input stage
  logic                           in_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;

  // history
  logic signed [SAMPLE_WIDTH-1:0] x1_r, x2_r, y1_r, y2_r;
  logic signed [WW-1:0]           w1_r, w2_r;
  logic [BP_W-1:0]                bp_r;

  // result stage
  logic                           out_vld_r;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_r;
  logic                           saturated_r;
  logic                           block_first_r;

  logic                           in_take, advance, first;
  logic signed [SAMPLE_WIDTH-1:0] hx1, hx2, hy1, hy2, y_df1, y_df2, y_sel;
  logic signed [WW-1:0]           hw1, hw2, w_new;
  pzb_clip_t                      clip;
  logic                           sat_sel;

  // handshake: result register frees up when taken
  assign advance      = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready  = !in_vld_r || advance;
  assign in_take      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid       = out_vld_r;
  assign out_if.out_sample  = out_sample_r;
  assign out_if.saturated   = saturated_r;
  assign out_if.block_first = block_first_r;

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r <= FORM_DF1;
      coef_r <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_FILTER_FORM:   form_r    <= cfg_if.data[0];
        REG_ZERO_COEF_ONE: coef_r.b1 <= coef_t'(cfg_if.data);
        REG_ZERO_COEF_TWO: coef_r.b2 <= coef_t'(cfg_if.data);
        REG_POLE_COEF_ONE: coef_r.a1 <= coef_t'(cfg_if.data);
        REG_POLE_COEF_TWO: coef_r.a2 <= coef_t'(cfg_if.data);
        default: ;
      endcase
    end
  end

  // history reads as zero on the first sample of a block
  assign first = (bp_r == '0);
  assign hx1   = first ? '0 : x1_r;
  assign hx2   = first ? '0 : x2_r;
  assign hy1   = first ? '0 : y1_r;
  assign hy2   = first ? '0 : y2_r;
  assign hw1   = first ? '0 : w1_r;
  assign hw2   = first ? '0 : w2_r;

  pzb_datapath #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_datapath (
    .x     (x_r),
    .x1    (hx1),
    .x2    (hx2),
    .y1    (hy1),
    .y2    (hy2),
    .w1    (hw1),
    .w2    (hw2),
    .coef  (coef_r),
    .y_df1 (y_df1),
    .y_df2 (y_df2),
    .w     (w_new),
    .clip  (clip)
  );

  // form select for result and flag
  assign y_sel   = (form_r == FORM_DF2) ? y_df2 : y_df1;
  assign sat_sel = (form_r == FORM_DF2) ? (clip.clip_w || clip.clip_df2)
                                        : clip.clip_df1;

  // control: stage valids and block position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      bp_r      <= '0;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        bp_r      <= (bp_r == BP_LAST) ? '0 : bp_r + 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload: input capture, history shift, result register
  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r <= in_if.in_sample;
    end
    if (advance) begin
      x2_r          <= hx1;
      x1_r          <= x_r;
      y2_r          <= hy1;
      y1_r          <= y_sel;
      w2_r          <= hw1;
      w1_r          <= w_new;
      out_sample_r  <= y_sel;
      saturated_r   <= sat_sel;
      block_first_r <= first;
    end
  end

  // block count wraps after the last sample of a block
  a_bp_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (bp_r == BP_LAST) |=> (bp_r == '0))
    else $error("block position did not wrap");

  // first-of-block flag follows the block position of the sample
  a_first_flag: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_if.block_first == $past(bp_r == '0)))
    else $error("block_first does not match block position");

  // a stalled result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_if.ready |-> !advance)
    else $error("result register overwritten while stalled");

  // input side never stalls while the input stage is empty
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_vld_r |-> in_if.ready)
    else $error("input stalled with empty input stage");

endmodule : pole_zero_biquad_filter

`default_nettype wire
